/* hdl/mdwt_pkg.sv */
// ---------------------------------------------------------------------------
// Wavelet analysis package
// Field widths, register indexes and arithmetic constants shared by the
// channel interfaces and the transform unit.
// ---------------------------------------------------------------------------
package mdwt_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int COEF_W     = 32;
  localparam int LEVEL_W    = 4;
  localparam int POS_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int TAP_W      = 32;
  localparam int TAP_REGS   = 4;
  localparam int FRAC_BITS  = 29;
  localparam int LOG_W      = 5;

  localparam logic MODE_LOAD = 1'b0;

  localparam logic [LEVEL_W-1:0] LOG_LENGTH_RESET  = 4'd10;
  localparam logic [LEVEL_W-1:0] LEVEL_COUNT_RESET = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LOG_LENGTH  = 3'd0,
    CFG_LEVEL_COUNT = 3'd1,
    CFG_TAP_PAIR_0  = 3'd2,
    CFG_TAP_PAIR_1  = 3'd3,
    CFG_TAP_PAIR_2  = 3'd4,
    CFG_TAP_PAIR_3  = 3'd5
  } cfg_reg_t;

endpackage

/* hdl/mdwt_channels.sv */
// ---------------------------------------------------------------------------
// Wavelet analysis channels
// Valid/ready channels for sample and read items, coefficient results and
// register writes.
// ---------------------------------------------------------------------------
interface mdwt_in_if import mdwt_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, mode, sample_value, input ready);
  modport sink   (input valid, mode, sample_value, output ready);
endinterface

interface mdwt_out_if import mdwt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [COEF_W-1:0] coefficient_value;
  logic [LEVEL_W-1:0]       level_index;
  logic                     band;
  logic [POS_W-1:0]         position;
  logic                     last_flag;
  logic                     error_flag;

  modport source (output valid, coefficient_value, level_index, band, position,
                  last_flag, error_flag, input ready);
  modport sink   (input valid, coefficient_value, level_index, band, position,
                  last_flag, error_flag, output ready);
endinterface

interface mdwt_cfg_if import mdwt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/multilevel_dwt_forward_unit.sv */
// Load item: written to the sample memory when taken. Read item: the readout
// state registers the result (an error result in the cycle after it is taken).
// One item at a time. The block that completes a load runs the transform if the
// level count is valid, passing the taps of each coefficient in turn through one
// multiply-accumulate unit fed by one memory read port; no item is taken meanwhile.
// Reset clears control state and configuration; not the data registers or memories.
// ---------------------------------------------------------------------------
// Multi-level forward wavelet unit
// Periodic Mallat analysis over a sample memory and a coefficient memory,
// with a sequential readout of every band of every level.
// ---------------------------------------------------------------------------
module multilevel_dwt_forward_unit import mdwt_pkg::*; #(
  parameter int MAX_LEN    = 1024,
  parameter int TAPS       = 4,
  parameter int MAX_LEVELS = 10
) (
  input  logic       clk,
  input  logic       rst_n,
  mdwt_in_if.sink    in_ch,
  mdwt_out_if.source out_ch,
  mdwt_cfg_if.sink   cfg_ch
);

  localparam int AW      = $clog2(MAX_LEN);
  localparam int IW      = AW + 1;
  localparam int CAW     = AW + 1;
  localparam int TW      = CAW + 1;
  localparam int CNTW    = $clog2(MAX_LEN + 1);
  localparam int MAX_LOG = $clog2(MAX_LEN + 1) - 1;
  localparam int TPW     = $clog2(TAPS);
  localparam int HALF    = TAPS / 2;
  localparam int ACCW    = 2 * TAP_W + 2;

  localparam logic signed [ACCW-1:0] ROUND_HALF = ACCW'(1) << (FRAC_BITS - 1);
  localparam logic signed [ACCW-1:0] SAT_MAX    = ACCW'(2**31 - 1);
  localparam logic signed [ACCW-1:0] SAT_MIN    = ~SAT_MAX;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_XFORM = 4'b0010,
    S_DRAIN = 4'b0100,
    S_RDATA = 4'b1000
  } state_t;

  typedef struct packed {
    logic           first;
    logic           last;
    logic           band;
    logic           lvl0;
    logic [TPW-1:0] tap;
    logic [CAW-1:0] wa;
  } tag_t;

  // Registers
  state_t                state_r;
  logic [LEVEL_W-1:0]    log_length_r;
  logic [LEVEL_W-1:0]    level_count_r;
  logic [CFG_DATA_W-1:0] tap_pair_r [TAP_REGS];
  logic [CNTW-1:0]       load_cnt_r;
  logic                  xready_r;
  logic [TW-1:0]         rp_r;
  logic [TW-1:0]         total_r;
  logic [LEVEL_W-1:0]    lvl_r;
  logic [LEVEL_W-1:0]    levels_r;
  logic [LOG_W-1:0]      lgn_r;
  logic [CAW-1:0]        base_r;
  logic [CAW-1:0]        prev_r;
  logic [AW-1:0]         k_r;
  logic                  band_r;
  logic [TPW-1:0]        tap_r;
  logic                  s1_v_r, s2_v_r, s3_v_r;
  tag_t                  s1_tag_r, s2_tag_r;
  logic [CAW-1:0]        s3_wa_r;
  logic signed [2*TAP_W-1:0] prod_r;
  logic signed [ACCW-1:0]    acc_r;
  logic [CNTW-1:0]       rd_off_r;
  logic [LOG_W-1:0]      rd_lgn_r;
  logic [LEVEL_W-1:0]    rd_lvl_r;
  logic                  out_valid_r;
  logic signed [COEF_W-1:0] out_coef_r;
  logic [LEVEL_W-1:0]    out_level_r;
  logic                  out_band_r;
  logic [POS_W-1:0]      out_pos_r;
  logic                  out_last_r;
  logic                  out_error_r;

  // Memories
  logic signed [SAMPLE_W-1:0] samp_mem [MAX_LEN];
  logic signed [SAMPLE_W-1:0] samp_rdata_r;
  logic [COEF_W-1:0]          coef_mem [2*MAX_LEN];
  logic [COEF_W-1:0]          coef_rdata_r;

  // Combinational
  logic                  in_ready;
  logic                  in_acc;
  logic                  is_load;
  logic                  err_rd;
  logic [LOG_W-1:0]      lg_eff;
  logic [CNTW-1:0]       len_w;
  logic [CNTW-1:0]       cnt_inc;
  logic                  blk_done;
  logic                  lvl_ok;
  logic                  iss_v;
  logic [IW-1:0]         n_w, h_w, mask_w, idx_w;
  logic                  k_last, tap_last;
  tag_t                  iss_tag;
  logic                  samp_we;
  logic                  coef_we;
  logic [CAW-1:0]        coef_ra;
  logic signed [COEF_W-1:0] s1_data;
  logic [TAP_W-1:0]      s1_tap_bits;
  logic signed [ACCW-1:0] rnd_w;
  logic [COEF_W-1:0]     sat_w;
  logic                  pipe_empty;
  logic [CNTW-1:0]       rd_n, rd_half, rd_pos;
  logic                  rd_band, rd_last;

  // Input handshake and block completion
  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign in_acc   = in_ch.valid && in_ready;
  assign is_load  = (in_ch.mode == MODE_LOAD);
  assign err_rd   = in_acc && !is_load && !xready_r;
  assign lg_eff   = (LOG_W'(log_length_r) > LOG_W'(MAX_LOG)) ? LOG_W'(MAX_LOG)
                                                              : LOG_W'(log_length_r);
  assign len_w    = CNTW'(1) << lg_eff;
  assign cnt_inc  = load_cnt_r + CNTW'(1);
  assign blk_done = (cnt_inc >= len_w);
  assign lvl_ok   = (level_count_r != '0) && (LOG_W'(level_count_r) <= lg_eff) &&
                    (LOG_W'(level_count_r) <= LOG_W'(MAX_LEVELS));

  // Tap fetch address, wrapped modulo the level length
  assign iss_v    = (state_r == S_XFORM);
  assign n_w      = IW'(1) << lgn_r;
  assign h_w      = n_w >> 1;
  assign mask_w   = n_w - IW'(1);
  assign idx_w    = ((IW'(k_r) << 1) + IW'(tap_r) - IW'(HALF)) & mask_w;
  assign k_last   = (IW'(k_r) + IW'(1)) == h_w;
  assign tap_last = (tap_r == TPW'(TAPS - 1));

  always_comb begin
    iss_tag.first = (tap_r == '0);
    iss_tag.last  = tap_last;
    iss_tag.band  = band_r;
    iss_tag.lvl0  = (lvl_r == '0);
    iss_tag.tap   = tap_r;
    iss_tag.wa    = base_r + (band_r ? CAW'(h_w) : CAW'(0)) + CAW'(k_r);
  end

  assign samp_we = in_acc && is_load;
  assign coef_we = s3_v_r;
  assign coef_ra = iss_v ? (prev_r + CAW'(idx_w)) : rp_r[CAW-1:0];

  // Sample memory
  always_ff @(posedge clk) begin
    if (samp_we) begin
      samp_mem[load_cnt_r[AW-1:0]] <= in_ch.sample_value;
    end
    samp_rdata_r <= samp_mem[idx_w[AW-1:0]];
  end

  // Coefficient memory
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[s3_wa_r] <= sat_w;
    end
    coef_rdata_r <= coef_mem[coef_ra];
  end

  // Select operand and tap for the multiplier
  assign s1_data     = s1_tag_r.lvl0 ? COEF_W'(samp_rdata_r) : $signed(coef_rdata_r);
  assign s1_tap_bits = s1_tag_r.band ? tap_pair_r[2'(s1_tag_r.tap)][TAP_W-1:0]
                                     : tap_pair_r[2'(s1_tag_r.tap)][CFG_DATA_W-1:TAP_W];

  // Round half up and saturate the accumulated sum
  always_comb begin
    rnd_w = (acc_r + ROUND_HALF) >>> FRAC_BITS;
    if (rnd_w > SAT_MAX) begin
      sat_w = SAT_MAX[COEF_W-1:0];
    end else if (rnd_w < SAT_MIN) begin
      sat_w = SAT_MIN[COEF_W-1:0];
    end else begin
      sat_w = rnd_w[COEF_W-1:0];
    end
  end

  assign pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;

  // Readout position decode
  assign rd_n    = CNTW'(1) << rd_lgn_r;
  assign rd_half = rd_n >> 1;
  assign rd_band = (rd_off_r >= rd_half);
  assign rd_pos  = rd_band ? (rd_off_r - rd_half) : rd_off_r;
  assign rd_last = ((rp_r + TW'(1)) >= total_r);

  // Datapath registers
  always_ff @(posedge clk) begin
    s1_tag_r <= iss_tag;
    s2_tag_r <= s1_tag_r;
    prod_r   <= $signed(s1_tap_bits) * s1_data;
    acc_r    <= s2_tag_r.first ? ACCW'(prod_r) : (acc_r + ACCW'(prod_r));
    s3_wa_r  <= s2_tag_r.wa;
    if (err_rd) begin
      out_coef_r  <= '0;
      out_level_r <= '0;
      out_band_r  <= 1'b0;
      out_pos_r   <= '0;
      out_last_r  <= 1'b0;
      out_error_r <= 1'b1;
    end else if (state_r == S_RDATA) begin
      out_coef_r  <= $signed(coef_rdata_r);
      out_level_r <= rd_lvl_r;
      out_band_r  <= rd_band;
      out_pos_r   <= POS_W'(rd_pos);
      out_last_r  <= rd_last;
      out_error_r <= 1'b0;
    end
  end

  // Control: configuration, sequencer, readout
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      log_length_r  <= LOG_LENGTH_RESET;
      level_count_r <= LEVEL_COUNT_RESET;
      for (int i = 0; i < TAP_REGS; i++) begin
        tap_pair_r[i] <= '0;
      end
      load_cnt_r  <= '0;
      xready_r    <= 1'b0;
      rp_r        <= '0;
      total_r     <= '0;
      lvl_r       <= '0;
      levels_r    <= '0;
      lgn_r       <= '0;
      base_r      <= '0;
      prev_r      <= '0;
      k_r         <= '0;
      band_r      <= 1'b0;
      tap_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      rd_off_r    <= '0;
      rd_lgn_r    <= '0;
      rd_lvl_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Register writes
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          CFG_LOG_LENGTH:  log_length_r  <= cfg_ch.data[LEVEL_W-1:0];
          CFG_LEVEL_COUNT: level_count_r <= cfg_ch.data[LEVEL_W-1:0];
          CFG_TAP_PAIR_0:  tap_pair_r[0] <= cfg_ch.data;
          CFG_TAP_PAIR_1:  tap_pair_r[1] <= cfg_ch.data;
          CFG_TAP_PAIR_2:  tap_pair_r[2] <= cfg_ch.data;
          CFG_TAP_PAIR_3:  tap_pair_r[3] <= cfg_ch.data;
          default: ;
        endcase
      end

      // Advance the multiply-accumulate pipeline
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r && s2_tag_r.last;

      // Drop a delivered result unless an error result replaces it
      if (out_valid_r && out_ch.ready && !err_rd) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (is_load) begin
              if (blk_done) begin
                load_cnt_r <= '0;
                xready_r   <= 1'b0;
                if (lvl_ok) begin
                  state_r  <= S_XFORM;
                  lvl_r    <= '0;
                  levels_r <= level_count_r;
                  lgn_r    <= lg_eff;
                  rd_lgn_r <= lg_eff;
                  base_r   <= '0;
                  prev_r   <= '0;
                  k_r      <= '0;
                  band_r   <= 1'b0;
                  tap_r    <= '0;
                end
              end else begin
                load_cnt_r <= cnt_inc;
              end
            end else if (xready_r) begin
              state_r <= S_RDATA;
            end else begin
              out_valid_r <= 1'b1;
            end
          end
        end
        S_XFORM: begin
          if (tap_last) begin
            tap_r <= '0;
            if (band_r) begin
              band_r <= 1'b0;
              if (k_last) begin
                k_r     <= '0;
                state_r <= S_DRAIN;
              end else begin
                k_r <= k_r + AW'(1);
              end
            end else begin
              band_r <= 1'b1;
            end
          end else begin
            tap_r <= tap_r + TPW'(1);
          end
        end
        S_DRAIN: begin
          // Hold until every write of this level has landed
          if (pipe_empty) begin
            if ((lvl_r + LEVEL_W'(1)) == levels_r) begin
              state_r  <= S_IDLE;
              xready_r <= 1'b1;
              rp_r     <= '0;
              total_r  <= TW'(base_r) + TW'(n_w);
              rd_off_r <= '0;
              rd_lvl_r <= '0;
            end else begin
              state_r <= S_XFORM;
              lvl_r   <= lvl_r + LEVEL_W'(1);
              prev_r  <= base_r;
              base_r  <= base_r + CAW'(n_w);
              lgn_r   <= lgn_r - LOG_W'(1);
            end
          end
        end
        S_RDATA: begin
          out_valid_r <= 1'b1;
          rp_r        <= rp_r + TW'(1);
          if (rd_last) begin
            xready_r <= 1'b0;
          end
          if ((rd_off_r + CNTW'(1)) == rd_n) begin
            rd_off_r <= '0;
            rd_lvl_r <= rd_lvl_r + LEVEL_W'(1);
            rd_lgn_r <= rd_lgn_r - LOG_W'(1);
          end else begin
            rd_off_r <= rd_off_r + CNTW'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Ports
  assign in_ch.ready              = in_ready;
  assign cfg_ch.ready             = 1'b1;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.coefficient_value = out_coef_r;
  assign out_ch.level_index       = out_level_r;
  assign out_ch.band              = out_band_r;
  assign out_ch.position          = out_pos_r;
  assign out_ch.last_flag         = out_last_r;
  assign out_ch.error_flag        = out_error_r;

  // Checks
  a_write_in_xform: assert property (@(posedge clk) disable iff (!rst_n)
    coef_we |-> (state_r == S_XFORM || state_r == S_DRAIN))
    else $error("coefficient write outside a transform");

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_error_r) |-> (out_coef_r == '0 && !out_last_r))
    else $error("error result carries data");

  a_fetch_origin: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r |-> $past(state_r == S_XFORM))
    else $error("tap fetch without a transform step");

  a_read_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RDATA) |-> xready_r)
    else $error("readout with no transform ready");

endmodule
